[sv/lkvc_pkg.sv]
package lkvc_pkg;

    // Number of slots in the table.
    localparam int ENTRIES = 16;
    // Width of a slot rank and of a slot count.
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    // Width of the capacity register.
    localparam int CAP_W   = 5;

    // Operation codes of the mode field.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Value returned by a get that misses.
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] value_out;
    } rsp_t;

endpackage

[sv/lru_key_value_cache.sv]
// Fully associative key/value cache with least-recently-used replacement.
// Requests enter on the s_ channel (valid/ready) as lkvc_pkg::req_t: a get
// looks up a key, a put inserts or updates a key with value_in. Each get
// gives one response on the m_ channel as lkvc_pkg::rsp_t with a hit flag
// and the stored value, or -1 on a miss; a put gives no response.
// The response is registered: an accepted get has its response in the
// output register from the next cycle on. All slots are compared and
// all ranks updated in the cycle of acceptance, so one request per cycle is
// sustained while the receiver keeps up.
// When the receiver stalls, the response waits in the output register and
// s_ready follows m_ready, so a new request goes in at the edge where the
// waiting response is taken.
// cfg_wr_en/cfg_wr_data write the capacity (0 acts as 1, values above the
// table size act as the table size); write it only while idle.
// Reset (aresetn low, synchronous) empties the table, sets the capacity to
// the full table and drops any pending response. No clearing pass is run.
module lru_key_value_cache (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lkvc_pkg::req_t            s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lkvc_pkg::rsp_t            m_data
);

    localparam int N = lkvc_pkg::ENTRIES;

    logic signed [31:0]              key_reg   [N];
    logic signed [31:0]              key_next  [N];
    logic signed [31:0]              value_reg [N];
    logic signed [31:0]              value_next[N];
    logic [lkvc_pkg::RANK_W-1:0]     rank_reg  [N];
    logic [lkvc_pkg::RANK_W-1:0]     rank_next [N];
    logic [N-1:0]                    valid_reg;
    logic [N-1:0]                    valid_next;
    logic [lkvc_pkg::CNT_W-1:0]      occ_reg;
    logic [lkvc_pkg::CNT_W-1:0]      occ_next;
    logic [lkvc_pkg::CAP_W-1:0]      capacity_reg;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    lkvc_pkg::rsp_t                  m_data_reg;
    lkvc_pkg::rsp_t                  m_data_next;

    logic                            accept;
    logic [N-1:0]                    hit_oh;
    logic                            hit_any;
    logic [lkvc_pkg::RANK_W-1:0]     hit_rank;
    logic signed [31:0]              hit_value;
    logic [lkvc_pkg::CNT_W-1:0]      eff_cap;
    logic                            evict;
    logic [lkvc_pkg::RANK_W-1:0]     last_rank;
    logic [N-1:0]                    victim_oh;
    logic [N-1:0]                    kept;
    logic [N-1:0]                    free_oh;

    // The input side takes a request when the output register is free or is
    // being emptied in this cycle.
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Clamp the capacity register into the usable range.
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = lkvc_pkg::CNT_W'(1);
        end else if (int'(capacity_reg) > N) begin
            eff_cap = lkvc_pkg::CNT_W'(N);
        end else begin
            eff_cap = lkvc_pkg::CNT_W'(capacity_reg);
        end
    end

    // Compare the key against every valid slot; at most one slot matches.
    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < N; i++) begin
            hit_oh[i] = valid_reg[i] && (key_reg[i] == s_data.key);
            if (hit_oh[i]) begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
        end
        hit_any = |hit_oh;
    end

    // Valid ranks always form 0 .. occupancy-1, so the least recent slot is
    // the one ranked occupancy-1. The new key goes to the lowest free slot
    // left after any eviction.
    assign evict     = (occ_reg >= eff_cap);
    assign last_rank = lkvc_pkg::RANK_W'(occ_reg - lkvc_pkg::CNT_W'(1));
    always_comb begin
        for (int i = 0; i < N; i++) begin
            victim_oh[i] = evict && valid_reg[i] && (rank_reg[i] == last_rank);
        end
    end
    assign kept    = valid_reg & ~victim_oh;
    assign free_oh = ~kept & (kept + N'(1));

    // Next state of the table for the accepted request.
    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        rank_next  = rank_reg;
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (accept) begin
            if (hit_any) begin
                // Touch the matching slot: more recent slots move back by one.
                for (int i = 0; i < N; i++) begin
                    if (hit_oh[i]) begin
                        rank_next[i] = '0;
                        if (s_data.mode == lkvc_pkg::MODE_PUT) begin
                            value_next[i] = s_data.value_in;
                        end
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + lkvc_pkg::RANK_W'(1);
                    end
                end
            end else if (s_data.mode == lkvc_pkg::MODE_PUT) begin
                // Insert a new key as most recent, all kept slots age by one.
                for (int i = 0; i < N; i++) begin
                    if (free_oh[i]) begin
                        key_next[i]   = s_data.key;
                        value_next[i] = s_data.value_in;
                        rank_next[i]  = '0;
                        valid_next[i] = 1'b1;
                    end else if (kept[i]) begin
                        rank_next[i] = rank_reg[i] + lkvc_pkg::RANK_W'(1);
                    end else begin
                        valid_next[i] = 1'b0;
                    end
                end
                if (!evict) begin
                    occ_next = occ_reg + lkvc_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Response register: loaded by every accepted get, held while stalled.
    always_comb begin
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        if (accept && (s_data.mode == lkvc_pkg::MODE_GET)) begin
            m_valid_next        = 1'b1;
            m_data_next.hit     = hit_any;
            m_data_next.value_out = hit_any ? hit_value : lkvc_pkg::MISS_VALUE;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            occ_reg      <= '0;
            m_valid_reg  <= 1'b0;
            capacity_reg <= lkvc_pkg::CAP_W'(16);
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            rank_reg    <= rank_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // Payload storage.
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        m_data_reg <= m_data_next;
    end

    // The fill count matches the valid bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match the valid slots");

    // A key is never held in two slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_oh))
        else $error("key stored in more than one slot");

    // A put gives no response.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.mode == lkvc_pkg::MODE_PUT) && m_ready) |=> !m_valid_reg)
        else $error("put produced a response");

    // An accepted get always leaves a response pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.mode == lkvc_pkg::MODE_GET)) |=> m_valid_reg)
        else $error("get response lost");

endmodule
